// File: rtl/prs_pkg.sv
// Shared types, constants and helpers for the packet rate shaper.
// No dependencies.
package prs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [31:0] DELAY_LIMIT_RST = 32'd50000;
    localparam logic [31:0] SEQ_NONE = 32'hFFFF_FFFF;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [5:0] HDR_V6 = 6'd48;
    localparam logic [5:0] HDR_V4 = 6'd28;
    localparam logic [15:0] MAX_RELEASE = 16'd16;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_TICK = 2'd1,
        OP_REFRESH = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        K_ACCEPTED = 4'd0,
        K_DELAY_FLUSH = 4'd1,
        K_NO_BW = 4'd2,
        K_FULL = 4'd3,
        K_RELEASED = 4'd4,
        K_TICK_DONE = 4'd5,
        K_REFRESH_OK = 4'd6,
        K_REFRESH_FLUSH = 4'd7,
        K_FLUSHED = 4'd8
    } kind_t;

    localparam logic CFG_BANDWIDTH = 1'b0;
    localparam logic CFG_DELAY_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [63:0] now_us;
        logic [15:0] payload_bytes;
        logic is_ipv6;
        logic [31:0] seq_num;
        logic [1:0] command;
        logic [31:0] send_flags;
        logic [7:0] traffic_class;
        logic remap;
    } in_word_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [31:0] out_seq;
        logic [15:0] out_payload;
        logic [1:0] out_command;
        logic [31:0] out_flags;
        logic [7:0] out_class;
        logic [63:0] send_time;
        logic [31:0] last_seq_sent;
        logic [4:0] queued;
        logic last;
    } out_word_t;

    // Divider handshake between sequencer and divider.
    typedef struct packed {
        logic start;
        logic [16:0] size;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_DIV,
        S_TICK_RD,
        S_TICK_CHK,
        S_REF_RD,
        S_REF_CHK,
        S_REF_DIV,
        S_OUT
    } state_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? TIME_MAX : s[63:0];
    endfunction

endpackage

// File: rtl/prs_stream_if.sv
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload type set by parameter.
interface prs_stream_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/packet_rate_shaper.sv
// Packet rate shaper top level: sequencer around descriptor memory and divider.
// Flush, full, delay and no-bandwidth results are registered on the accept;
// an accepted enqueue waits for the 37-step divide; a tick reads and checks the head
// per release; refresh reads, writes back and divides each queued entry.
// One item at a time; words are taken only when idle with the output register free.
// Reset: queue empty, next send time 0, last sequence all ones,
// bandwidth 0, delay limit 50000. Entry memory is not cleared.
module packet_rate_shaper
    import prs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    prs_stream_if.sink in_ch,
    prs_stream_if.source out_ch,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    // time 64, size 17, seq 32, flags 32, class 8, command 2, v6 1
    localparam int EW = 64 + 17 + 32 + 32 + 8 + 2 + 1;

    typedef struct packed {
        logic [63:0] t;
        logic [16:0] size;
        logic [31:0] seq;
        logic [31:0] flags;
        logic [7:0] cls;
        logic [1:0] cmd;
        logic v6;
    } entry_t;

    logic [31:0] bw_reg, dl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= '0;
            dl_reg <= DELAY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BANDWIDTH: bw_reg <= cfg_data;
                CFG_DELAY_LIMIT: dl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    in_word_t item_reg, item_next;
    out_word_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;
    logic [63:0] nst_reg, nst_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] lss_reg, lss_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [4:0] rel_reg, rel_next;
    logic flushed_reg, flushed_next;
    entry_t ent_reg, ent_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata, rdata;
    div_req_t dreq;
    div_rsp_t drsp;

    prs_entry_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW), .DW(EW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    prs_divider u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .bandwidth(bw_reg), .rsp(drsp)
    );

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = CW'(h) + i;
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        return AW'(s);
    endfunction

    logic out_free;
    logic [16:0] in_size;
    logic [63:0] in_stamp;
    logic [63:0] nst_upd;

    assign out_free = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = obuf_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        obuf_next = obuf_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        nst_next = nst_reg;
        head_next = head_reg;
        cnt_next = cnt_reg;
        lss_next = lss_reg;
        idx_next = idx_reg;
        rel_next = rel_reg;
        flushed_next = flushed_reg;
        ent_next = ent_reg;
        we = 1'b0;
        waddr = slot(head_reg, cnt_reg);
        wdata = ent_reg;
        raddr = slot(head_reg, idx_reg);
        dreq = '0;
        in_size = '0;
        in_stamp = '0;
        nst_upd = sat_add(nst_reg, drsp.quotient);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    item_next = in_ch.data;
                    obuf_next = '0;
                    obuf_next.out_seq = in_ch.data.seq_num;
                    obuf_next.out_payload = in_ch.data.payload_bytes;
                    obuf_next.last = 1'b1;
                    in_size = {1'b0, in_ch.data.payload_bytes}
                        + (in_ch.data.is_ipv6 ? 17'(HDR_V6) : 17'(HDR_V4));
                    in_stamp = (nst_reg < in_ch.data.now_us) ? in_ch.data.now_us : nst_reg;
                    unique case (op_t'(in_ch.data.operation))
                        OP_ENQ:
                        begin
                            if (in_ch.data.payload_bytes != '0 && bw_reg == '0)
                            begin
                                obuf_next.kind = K_NO_BW;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                nst_next = in_stamp;
                                obuf_next.send_time = in_stamp;
                                if (in_stamp - in_ch.data.now_us > {32'b0, dl_reg})
                                begin
                                    head_next = '0;
                                    cnt_next = '0;
                                    nst_next = in_ch.data.now_us;
                                    obuf_next.kind = K_DELAY_FLUSH;
                                    ovalid_next = 1'b1;
                                end
                                else if (cnt_reg >= CW'(QUEUE_DEPTH))
                                begin
                                    obuf_next.kind = K_FULL;
                                    ovalid_next = 1'b1;
                                end
                                else
                                begin
                                    ent_next.t = in_stamp;
                                    ent_next.size = in_size;
                                    ent_next.seq = in_ch.data.seq_num;
                                    ent_next.flags = in_ch.data.send_flags;
                                    ent_next.cls = in_ch.data.traffic_class;
                                    ent_next.cmd = in_ch.data.command;
                                    ent_next.v6 = in_ch.data.is_ipv6;
                                    obuf_next.kind = K_ACCEPTED;
                                    dreq.start = 1'b1;
                                    dreq.size = in_size;
                                    state_next = S_ENQ_DIV;
                                end
                            end
                            obuf_next.last_seq_sent = lss_reg;
                            obuf_next.queued = 5'(cnt_next);
                        end
                        OP_TICK:
                        begin
                            rel_next = '0;
                            idx_next = '0;
                            state_next = S_TICK_RD;
                        end
                        OP_REFRESH:
                        begin
                            nst_next = in_ch.data.now_us;
                            idx_next = '0;
                            flushed_next = 1'b0;
                            state_next = S_REF_RD;
                        end
                        default:
                        begin
                            head_next = '0;
                            cnt_next = '0;
                            nst_next = in_ch.data.now_us;
                            obuf_next.out_seq = '0;
                            obuf_next.out_payload = '0;
                            obuf_next.kind = K_FLUSHED;
                            obuf_next.send_time = in_ch.data.now_us;
                            obuf_next.last_seq_sent = lss_reg;
                            obuf_next.queued = '0;
                            ovalid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ENQ_DIV:
            begin
                if (drsp.done)
                begin
                    we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    nst_next = nst_upd;
                    obuf_next.queued = 5'(cnt_reg + 1'b1);
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                // head read issued; data lands next cycle
                raddr = head_reg;
                state_next = S_TICK_CHK;
            end
            S_TICK_CHK:
            begin
                if (out_free)
                begin
                    obuf_next = '0;
                    obuf_next.last_seq_sent = lss_reg;
                    obuf_next.queued = 5'(cnt_reg);
                    if (cnt_reg != '0 && 16'(rel_reg) < MAX_RELEASE
                        && rdata.t <= item_reg.now_us)
                    begin
                        if (rdata.seq != SEQ_NONE)
                            lss_next = rdata.seq;
                        head_next = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        cnt_next = cnt_reg - 1'b1;
                        rel_next = rel_reg + 1'b1;
                        obuf_next.kind = K_RELEASED;
                        obuf_next.out_seq = rdata.seq;
                        obuf_next.out_payload = 16'(rdata.size
                            - (rdata.v6 ? 17'(HDR_V6) : 17'(HDR_V4)));
                        obuf_next.out_command = rdata.cmd;
                        obuf_next.out_flags = rdata.flags;
                        obuf_next.out_class = rdata.cls;
                        obuf_next.send_time = rdata.t;
                        obuf_next.last_seq_sent = lss_next;
                        obuf_next.queued = 5'(cnt_next);
                        ovalid_next = 1'b1;
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        obuf_next.kind = K_TICK_DONE;
                        obuf_next.last = 1'b1;
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_REF_RD:
            begin
                if (idx_reg >= cnt_reg)
                    state_next = S_OUT;
                else
                    state_next = S_REF_CHK;
            end
            S_REF_CHK:
            begin
                ent_next = rdata;
                if (item_reg.remap)
                    ent_next.cls = item_reg.traffic_class;
                ent_next.t = nst_reg;
                waddr = slot(head_reg, idx_reg);
                wdata = ent_next;
                we = 1'b1;
                if (nst_reg - item_reg.now_us > {32'b0, dl_reg})
                begin
                    head_next = '0;
                    cnt_next = '0;
                    nst_next = item_reg.now_us;
                    flushed_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.size = rdata.size;
                    state_next = S_REF_DIV;
                end
            end
            S_REF_DIV:
            begin
                if (drsp.done)
                begin
                    nst_next = nst_upd;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_REF_RD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    obuf_next = '0;
                    obuf_next.kind = flushed_reg ? K_REFRESH_FLUSH : K_REFRESH_OK;
                    obuf_next.send_time = nst_reg;
                    obuf_next.last_seq_sent = lss_reg;
                    obuf_next.queued = 5'(cnt_reg);
                    obuf_next.last = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            nst_reg <= '0;
            head_reg <= '0;
            cnt_reg <= '0;
            lss_reg <= SEQ_NONE;
            idx_reg <= '0;
            rel_reg <= '0;
            flushed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            nst_reg <= nst_next;
            head_reg <= head_next;
            cnt_reg <= cnt_next;
            lss_reg <= lss_next;
            idx_reg <= idx_next;
            rel_reg <= rel_next;
            flushed_reg <= flushed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        obuf_reg <= obuf_next;
        ent_reg <= ent_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |-> state_reg == S_IDLE)
        else $error("word accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_ENQ_DIV || state_reg == S_REF_DIV)
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(obuf_reg))
        else $error("output word dropped while stalled");
endmodule

// File: rtl/prs_divider.sv
// Radix-2 restoring divider: 1e6 * size / bandwidth, one bit a cycle.
// Depends on prs_pkg.
module prs_divider
    import prs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  div_req_t req,
    input  logic [31:0] bandwidth,
    output div_rsp_t rsp
);
    // dividend fits in 37 bits (1e6 * 131071)
    logic [36:0] dvd_reg, dvd_next;
    logic [36:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [33:0] trial;

    always_comb
    begin
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (req.start)
        begin
            dvd_next = {20'b0, req.size} * {17'b0, USEC_PER_SEC};
            quo_next = '0;
            rem_next = '0;
            cnt_next = 6'd37;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, dvd_reg[36]} - {2'b0, bandwidth};
            dvd_next = {dvd_reg[35:0], 1'b0};
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[35:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], dvd_reg[36]};
                quo_next = {quo_reg[35:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = (bandwidth == '0) ? TIME_MAX : {27'b0, quo_reg};
endmodule

// File: rtl/prs_entry_ram.sv
// Descriptor memory: one write port, one registered read port.
// Depends on nothing.
module prs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  logic clk,
    input  logic we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
